>>> rtl/pci_config_scan_engine_macros.svh
// Assertion macros for the configuration scan engine.
`ifndef PCI_CONFIG_SCAN_ENGINE_MACROS_SVH
`define PCI_CONFIG_SCAN_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define PCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

  localparam int DefDeviceCount = 32;
  localparam int DefMaxFunctions = 8;
  localparam int DefCapHopLimit = 48;

  localparam logic [31:0] ENABLE_BIT = 32'h8000_0000;
  localparam int MultiBitPos = 23;
  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam logic [7:0] REG_CAP_PTR = 8'h34;
  localparam logic [7:0] REG_HEADER = 8'h0C;
  localparam logic [7:0] REG_CLASS = 8'h08;
  localparam logic [7:0] REG_VENDOR = 8'h00;
  localparam logic [7:0] DWORD_MASK = 8'hFC;

  localparam logic [1:0] OP_SCAN = 2'd0;
  localparam logic [1:0] OP_CAP = 2'd1;
  localparam logic [1:0] OP_RESP = 2'd2;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam logic [1:0] CFG_CLASS_VALUE = 2'd0;
  localparam logic [1:0] CFG_CLASS_MASK = 2'd1;
  localparam logic [1:0] CFG_BUS_NUMBER = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] read_data;
    logic [31:0] function_address;
    logic [7:0]  wanted_capability;
  } pcs_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } pcs_result_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [31:0] wdata;
  } pcs_cfg_wr_t;

  function automatic logic [31:0] pack_addr(input logic [7:0] bus, input logic [4:0] dev,
                                            input logic [2:0] fn, input logic [7:0] offs);
    return {8'h00, bus, dev, fn, offs & DWORD_MASK};
  endfunction

endpackage
`default_nettype wire

>>> rtl/pcs_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module pcs_in_stage
  import pcs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire pcs_item_t item_i,
  input  wire logic      take_i,
  output logic           valid_o,
  output pcs_item_t      item_o
);

  logic      valid_q;
  pcs_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pcs_step.sv
`timescale 1ns / 1ps
`default_nettype none
module pcs_step
  import pcs_pkg::*;
#(
  parameter int DEVICE_COUNT = DefDeviceCount,
  parameter int MAX_FUNCTIONS = DefMaxFunctions,
  parameter int CAP_HOP_LIMIT = DefCapHopLimit
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pcs_cfg_wr_t cfg_i,
  input  wire pcs_item_t   item_i,
  input  wire logic        adv_i,
  output pcs_result_t      result_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_VEN0 = 3'd1;
  localparam logic [2:0] PH_HDR = 3'd2;
  localparam logic [2:0] PH_FVEN = 3'd3;
  localparam logic [2:0] PH_CLASS = 3'd4;
  localparam logic [2:0] PH_CPTR = 3'd5;
  localparam logic [2:0] PH_CENT = 3'd6;

  logic [31:0] class_value_q, class_mask_q;
  logic [7:0]  bus_q;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  dev_q, dev_d;
  logic [2:0]  fn_q, fn_d;
  logic        multi_q, multi_d;
  logic [7:0]  ptr_q, ptr_d;
  logic [5:0]  hop_q, hop_d;
  logic [7:0]  id_q, id_d;
  logic [31:0] base_q, base_d;

  logic [5:0]  nd;
  logic [3:0]  nf, fn_limit;
  logic        dev_more, fn_more;
  logic [7:0]  nxt;

  pcs_result_t nd_res, nf_res;
  logic [2:0]  nd_phase, nf_phase;
  logic [4:0]  nd_dev, nf_dev;
  logic [2:0]  nd_fn, nf_fn;

  always_comb begin
    nd       = {1'b0, dev_q} + 6'd1;
    nf       = {1'b0, fn_q} + 4'd1;
    fn_limit = multi_q ? 4'(MAX_FUNCTIONS) : 4'd1;
    dev_more = nd < 6'(DEVICE_COUNT);
    fn_more  = nf < fn_limit;
    nxt      = item_i.read_data[15:8] & DWORD_MASK;

    if (dev_more) begin
      nd_dev       = nd[4:0];
      nd_fn        = 3'd0;
      nd_phase     = PH_VEN0;
      nd_res.kind  = KIND_READ;
      nd_res.value = ENABLE_BIT | pack_addr(bus_q, nd[4:0], 3'd0, REG_VENDOR);
    end else begin
      nd_dev       = dev_q;
      nd_fn        = fn_q;
      nd_phase     = PH_IDLE;
      nd_res.kind  = KIND_NONE;
      nd_res.value = '0;
    end

    if (fn_more) begin
      nf_dev       = dev_q;
      nf_fn        = nf[2:0];
      nf_phase     = PH_FVEN;
      nf_res.kind  = KIND_READ;
      nf_res.value = ENABLE_BIT | pack_addr(bus_q, dev_q, nf[2:0], REG_VENDOR);
    end else begin
      nf_dev   = nd_dev;
      nf_fn    = nd_fn;
      nf_phase = nd_phase;
      nf_res   = nd_res;
    end
  end

  always_comb begin
    phase_d = phase_q;
    dev_d   = dev_q;
    fn_d    = fn_q;
    multi_d = multi_q;
    ptr_d   = ptr_q;
    hop_d   = hop_q;
    id_d    = id_q;
    base_d  = base_q;
    result_o.kind  = KIND_IGNORED;
    result_o.value = '0;

    unique case (item_i.opcode)
      OP_SCAN: begin
        dev_d   = '0;
        fn_d    = '0;
        multi_d = 1'b0;
        phase_d = PH_VEN0;
        result_o.kind  = KIND_READ;
        result_o.value = ENABLE_BIT | pack_addr(bus_q, 5'd0, 3'd0, REG_VENDOR);
      end
      OP_CAP: begin
        base_d  = item_i.function_address;
        id_d    = item_i.wanted_capability;
        hop_d   = '0;
        ptr_d   = '0;
        phase_d = PH_CPTR;
        result_o.kind  = KIND_READ;
        result_o.value = ENABLE_BIT | (item_i.function_address + {24'd0, REG_CAP_PTR});
      end
      OP_RESP: begin
        unique case (phase_q)
          PH_VEN0: begin
            if (item_i.read_data[15:0] == VENDOR_NONE) begin
              dev_d    = nd_dev;
              fn_d     = nd_fn;
              phase_d  = nd_phase;
              result_o = nd_res;
            end else begin
              phase_d = PH_HDR;
              result_o.kind  = KIND_READ;
              result_o.value = ENABLE_BIT | pack_addr(bus_q, dev_q, 3'd0, REG_HEADER);
            end
          end
          PH_HDR: begin
            multi_d = item_i.read_data[MultiBitPos];
            fn_d    = '0;
            phase_d = PH_FVEN;
            result_o.kind  = KIND_READ;
            result_o.value = ENABLE_BIT | pack_addr(bus_q, dev_q, 3'd0, REG_VENDOR);
          end
          PH_FVEN: begin
            if (item_i.read_data[15:0] == VENDOR_NONE) begin
              dev_d    = nf_dev;
              fn_d     = nf_fn;
              phase_d  = nf_phase;
              result_o = nf_res;
            end else begin
              phase_d = PH_CLASS;
              result_o.kind  = KIND_READ;
              result_o.value = ENABLE_BIT | pack_addr(bus_q, dev_q, fn_q, REG_CLASS);
            end
          end
          PH_CLASS: begin
            if ((item_i.read_data & class_mask_q) == class_value_q) begin
              phase_d = PH_IDLE;
              result_o.kind  = KIND_FOUND;
              result_o.value = ENABLE_BIT | pack_addr(bus_q, dev_q, fn_q, REG_VENDOR);
            end else begin
              dev_d    = nf_dev;
              fn_d     = nf_fn;
              phase_d  = nf_phase;
              result_o = nf_res;
            end
          end
          PH_CPTR: begin
            ptr_d = item_i.read_data[7:0] & DWORD_MASK;
            if ((item_i.read_data[7:0] & DWORD_MASK) == 8'd0) begin
              phase_d = PH_IDLE;
              result_o.kind = KIND_NONE;
            end else begin
              hop_d   = 6'd1;
              phase_d = PH_CENT;
              result_o.kind  = KIND_READ;
              result_o.value = ENABLE_BIT
                             | (base_q + {24'd0, item_i.read_data[7:0] & DWORD_MASK});
            end
          end
          PH_CENT: begin
            if (item_i.read_data[7:0] == id_q) begin
              phase_d = PH_IDLE;
              result_o.kind  = KIND_FOUND;
              result_o.value = {24'd0, ptr_q};
            end else if (nxt == 8'd0 || hop_q >= 6'(CAP_HOP_LIMIT)) begin
              phase_d = PH_IDLE;
              result_o.kind = KIND_NONE;
            end else begin
              ptr_d = nxt;
              hop_d = hop_q + 6'd1;
              result_o.kind  = KIND_READ;
              result_o.value = ENABLE_BIT | (base_q + {24'd0, nxt});
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_value_q <= '0;
      class_mask_q  <= '0;
      bus_q         <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_CLASS_VALUE: class_value_q <= cfg_i.wdata;
        CFG_CLASS_MASK:  class_mask_q  <= cfg_i.wdata;
        CFG_BUS_NUMBER:  bus_q         <= cfg_i.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dev_q   <= '0;
      fn_q    <= '0;
      multi_q <= 1'b0;
      ptr_q   <= '0;
      hop_q   <= '0;
      id_q    <= '0;
      base_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      dev_q   <= dev_d;
      fn_q    <= fn_d;
      multi_q <= multi_d;
      ptr_q   <= ptr_d;
      hop_q   <= hop_d;
      id_q    <= id_d;
      base_q  <= base_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pcs_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module pcs_out_stage
  import pcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire pcs_result_t result_i,
  output logic             can_take_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output pcs_result_t      result_o
);

  logic        valid_q;
  pcs_result_t result_q;

  assign can_take_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign result_o   = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && can_take_o) begin
      result_q <= result_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pci_config_scan_engine.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    opcode, read_data, function_address,
//                                                 wanted_capability
// out       output     out_valid_o / out_ready_i  kind, value
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One transaction in gives one transaction out, held first in the input register and then in the result register.
// Sustained rate is one transaction per cycle while the output is not stalled: the step
// logic between the input register and the result register decides each item combinationally.
// Reset clears walk state and configuration registers at once; no clearing pass.
// A stalled output holds its result while the input register still takes one more.
`timescale 1ns / 1ps
`default_nettype none
`include "pci_config_scan_engine_macros.svh"
module pci_config_scan_engine
  import pcs_pkg::*;
#(
  parameter int DEVICE_COUNT = DefDeviceCount,
  parameter int MAX_FUNCTIONS = DefMaxFunctions,
  parameter int CAP_HOP_LIMIT = DefCapHopLimit
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  in_opcode_i,
  input  wire logic [31:0] in_read_data_i,
  input  wire logic [31:0] in_function_address_i,
  input  wire logic [7:0]  in_wanted_capability_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [31:0]      out_value_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  pcs_item_t   in_item, stage_item;
  pcs_result_t step_res, out_res;
  pcs_cfg_wr_t cfg_wr;
  logic        stage_valid, out_can_take, adv;

  assign in_item = {in_opcode_i, in_read_data_i, in_function_address_i,
                    in_wanted_capability_i};

  assign cfg_wr = {cfg_we_i, cfg_idx_i, cfg_wdata_i};

  assign adv = stage_valid && out_can_take;

  pcs_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .take_i  (out_can_take),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  pcs_step #(
    .DEVICE_COUNT  (DEVICE_COUNT),
    .MAX_FUNCTIONS (MAX_FUNCTIONS),
    .CAP_HOP_LIMIT (CAP_HOP_LIMIT)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_wr),
    .item_i   (stage_item),
    .adv_i    (adv),
    .result_o (step_res)
  );

  pcs_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (stage_valid),
    .result_i   (step_res),
    .can_take_o (out_can_take),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .result_o   (out_res)
  );

  assign out_kind_o  = out_res.kind;
  assign out_value_o = out_res.value;

  `PCS_ASSERT(a_read_has_enable, clk_i, rst_ni,
              (out_valid_o && out_kind_o == KIND_READ) |-> out_value_o[31],
              "read request without enable bit")
  `PCS_ASSERT(a_ignored_zero, clk_i, rst_ni,
              (out_valid_o && out_kind_o == KIND_IGNORED) |-> (out_value_o == 32'd0),
              "ignored result with nonzero value")
  `PCS_ASSERT(a_none_zero, clk_i, rst_ni,
              (out_valid_o && out_kind_o == KIND_NONE) |-> (out_value_o == 32'd0),
              "not-found result with nonzero value")
  `PCS_ASSERT_NEVER(a_stall_empty, clk_i, rst_ni, !in_ready_o && !stage_valid,
                    "input stalled with empty input register")

endmodule
`default_nettype wire

>>> tb/pci_config_scan_engine_tb.sv
`timescale 1ns / 1ps
module pci_config_scan_engine_tb;
  import pcs_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [1:0] OpUndefined = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VEN0,
    PH_HDR,
    PH_FVEN,
    PH_CLASS,
    PH_CPTR,
    PH_CENT
  } walk_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  in_opcode_i = OP_RESP;
  logic [31:0] in_read_data_i = '0;
  logic [31:0] in_function_address_i = '0;
  logic [7:0]  in_wanted_capability_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [31:0] out_value_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_CLASS_VALUE;
  logic [31:0] cfg_wdata_i = '0;

  pci_config_scan_engine DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .in_opcode_i            (in_opcode_i),
    .in_read_data_i         (in_read_data_i),
    .in_function_address_i  (in_function_address_i),
    .in_wanted_capability_i (in_wanted_capability_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .out_kind_o             (out_kind_o),
    .out_value_o            (out_value_o),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int cycle_count = 0;
  int failures = 0;
  int send_gap_max = 14;
  int recv_gap_max = 14;
  bit long_walk = 1'b0;

  pcs_result_t expected_results[$];

  // scan engine shadow state
  logic [31:0] cls_value = '0;
  logic [31:0] cls_mask = '0;
  logic [7:0]  scan_bus = '0;
  walk_phase_e phase = PH_IDLE;
  logic [4:0]  dev_idx = '0;
  logic [2:0]  fn_idx = '0;
  logic        multi_fn = 1'b0;
  logic [7:0]  cap_ptr = '0;
  logic [5:0]  hops = '0;
  logic [7:0]  want_id = '0;
  logic [31:0] cap_base = '0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("pci_config_scan_engine verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] cfg_addr(input logic [4:0] dev, input logic [2:0] fn,
                                           input logic [7:0] offs);
    return {8'h00, scan_bus, dev, fn, offs & DWORD_MASK};
  endfunction

  function automatic pcs_result_t read_req(input logic [31:0] addr);
    pcs_result_t r;
    r = '{kind: KIND_READ, value: ENABLE_BIT | addr};
    return r;
  endfunction

  function automatic pcs_result_t advance_device();
    pcs_result_t r;
    if (int'(dev_idx) + 1 < DefDeviceCount) begin
      dev_idx = dev_idx + 5'd1;
      fn_idx = '0;
      phase = PH_VEN0;
      r = read_req(cfg_addr(dev_idx, 3'd0, REG_VENDOR));
    end else begin
      phase = PH_IDLE;
      r = '{kind: KIND_NONE, value: 32'd0};
    end
    return r;
  endfunction

  function automatic pcs_result_t advance_function();
    pcs_result_t r;
    int fn_limit;
    fn_limit = multi_fn ? DefMaxFunctions : 1;
    if (int'(fn_idx) + 1 < fn_limit) begin
      fn_idx = fn_idx + 3'd1;
      phase = PH_FVEN;
      r = read_req(cfg_addr(dev_idx, fn_idx, REG_VENDOR));
    end else begin
      r = advance_device();
    end
    return r;
  endfunction

  function automatic pcs_result_t take_response(input logic [31:0] data);
    pcs_result_t r;
    logic [7:0] nxt;
    r = '{kind: KIND_IGNORED, value: 32'd0};
    case (phase)
      PH_VEN0: begin
        if (data[15:0] == VENDOR_NONE) begin
          r = advance_device();
        end else begin
          phase = PH_HDR;
          r = read_req(cfg_addr(dev_idx, 3'd0, REG_HEADER));
        end
      end
      PH_HDR: begin
        multi_fn = data[MultiBitPos];
        fn_idx = '0;
        phase = PH_FVEN;
        r = read_req(cfg_addr(dev_idx, 3'd0, REG_VENDOR));
      end
      PH_FVEN: begin
        if (data[15:0] == VENDOR_NONE) begin
          r = advance_function();
        end else begin
          phase = PH_CLASS;
          r = read_req(cfg_addr(dev_idx, fn_idx, REG_CLASS));
        end
      end
      PH_CLASS: begin
        if ((data & cls_mask) == cls_value) begin
          phase = PH_IDLE;
          r = '{kind: KIND_FOUND, value: ENABLE_BIT | cfg_addr(dev_idx, fn_idx, REG_VENDOR)};
        end else begin
          r = advance_function();
        end
      end
      PH_CPTR: begin
        cap_ptr = data[7:0] & DWORD_MASK;
        if (cap_ptr == 8'd0) begin
          phase = PH_IDLE;
          r = '{kind: KIND_NONE, value: 32'd0};
        end else begin
          hops = 6'd1;
          phase = PH_CENT;
          r = read_req(cap_base + {24'd0, cap_ptr});
        end
      end
      PH_CENT: begin
        nxt = data[15:8] & DWORD_MASK;
        if (data[7:0] == want_id) begin
          phase = PH_IDLE;
          r = '{kind: KIND_FOUND, value: {24'd0, cap_ptr}};
        end else if (nxt == 8'd0 || hops >= 6'(DefCapHopLimit)) begin
          phase = PH_IDLE;
          r = '{kind: KIND_NONE, value: 32'd0};
        end else begin
          cap_ptr = nxt;
          hops = hops + 6'd1;
          r = read_req(cap_base + {24'd0, cap_ptr});
        end
      end
      default: begin
        phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  task automatic predict_step(input pcs_item_t it);
    pcs_result_t r;
    r = '{kind: KIND_IGNORED, value: 32'd0};
    case (it.opcode)
      OP_SCAN: begin
        dev_idx = '0;
        fn_idx = '0;
        multi_fn = 1'b0;
        phase = PH_VEN0;
        r = read_req(cfg_addr(5'd0, 3'd0, REG_VENDOR));
      end
      OP_CAP: begin
        cap_base = it.function_address;
        want_id = it.wanted_capability;
        hops = '0;
        cap_ptr = '0;
        phase = PH_CPTR;
        r = read_req(cap_base + {24'd0, REG_CAP_PTR});
      end
      OP_RESP: begin
        r = take_response(it.read_data);
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] data,
                           input logic [31:0] addr, input logic [7:0] cap_id);
    int gap;
    pcs_item_t it;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_opcode_i <= op;
    in_read_data_i <= data;
    in_function_address_i <= addr;
    in_wanted_capability_i <= cap_id;
    do @(posedge clk_i); while (!in_ready_o);
    it = '{opcode: op, read_data: data, function_address: addr, wanted_capability: cap_id};
    predict_step(it);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CLASS_VALUE: cls_value = data;
      CFG_CLASS_MASK:  cls_mask = data;
      CFG_BUS_NUMBER:  scan_bus = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [31:0] value, input logic [31:0] mask,
                              input logic [7:0] bus);
    logic [23:0] junk;
    junk = 24'($urandom());
    write_reg(CFG_CLASS_VALUE, value);
    write_reg(CFG_CLASS_MASK, mask);
    write_reg(CFG_BUS_NUMBER, {junk, bus});
  endtask

  function automatic logic [31:0] shaped_response();
    logic [31:0] r;
    r = $urandom();
    case (phase)
      PH_VEN0, PH_FVEN: begin
        if ($urandom_range(0, 9) < (long_walk ? 7 : 5)) begin
          r[15:0] = VENDOR_NONE;
        end else if (r[15:0] == VENDOR_NONE) begin
          r[0] = 1'b0;
        end
      end
      PH_CLASS: begin
        if (!long_walk && $urandom_range(0, 3) == 0) begin
          r = (r & ~cls_mask) | (cls_value & cls_mask);
        end else if ((r & cls_mask) == cls_value && cls_mask != 0) begin
          r = r ^ (cls_mask & (~cls_mask + 32'd1));
        end
      end
      PH_CPTR: begin
        if (!long_walk && $urandom_range(0, 6) == 0) begin
          r[7:2] = 6'd0;
        end else if (r[7:2] == 6'd0) begin
          r[7:2] = 6'($urandom_range(1, 63));
        end
      end
      PH_CENT: begin
        if (!long_walk && $urandom_range(0, 4) == 0) begin
          r[7:0] = want_id;
        end else begin
          if (r[7:0] == want_id) r[7:0] = want_id + 8'd1;
          if (!long_walk && $urandom_range(0, 6) == 0) begin
            r[15:10] = 6'd0;
          end else if (r[15:10] == 6'd0) begin
            r[15:10] = 6'($urandom_range(1, 63));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_base();
    logic [31:0] b;
    b = $urandom();
    if ($urandom_range(0, 9) == 0) b[31:8] = 24'hFF_FFFF;
    return b;
  endfunction

  task automatic run_random(input int count);
    int roll;
    int scan_th;
    int cap_th;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      scan_th = long_walk ? 0 : 3;
      cap_th = long_walk ? 1 : 6;
      if (roll < scan_th || (phase == PH_IDLE && roll < 50)) begin
        long_walk = ($urandom_range(0, 9) < 3);
        send_item(OP_SCAN, $urandom(), $urandom(), 8'($urandom()));
      end else if (roll < cap_th || (phase == PH_IDLE && roll < 94)) begin
        long_walk = ($urandom_range(0, 9) < 3);
        send_item(OP_CAP, $urandom(), pick_base(), 8'($urandom()));
      end else if (roll < 8 && phase != PH_IDLE) begin
        send_item(OpUndefined, $urandom(), $urandom(), 8'($urandom()));
      end else if (roll < 10 || phase == PH_IDLE) begin
        send_item(OP_RESP, $urandom(), $urandom(), 8'($urandom()));
      end else begin
        send_item(OP_RESP, shaped_response(), $urandom(), 8'($urandom()));
      end
    end
  endtask

  task automatic test_idle_responses();
    send_item(OP_RESP, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(OP_RESP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(OpUndefined, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_default_scan();
    send_item(OP_SCAN, 32'h0, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h1234_FFFF, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h5678_8086, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h0080_0000, 32'h0, 8'h00);
    send_item(OP_RESP, 32'hFFFF_FFFF, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h0001_0002, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h0C03_3000, 32'h0, 8'h00);
  endtask

  task automatic test_capability_walk();
    send_item(OP_CAP, 32'h0, 32'hFFFF_FFF0, 8'hFF);
    send_item(OP_RESP, 32'h0000_0037, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h0000_4305, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h0000_00FF, 32'h0, 8'h00);
    send_item(OP_CAP, 32'h0, 32'h0000_0000, 8'h00);
    send_item(OP_RESP, 32'hFFFF_FF03, 32'h0, 8'h00);
    send_item(OP_CAP, 32'h0, 32'h0000_1000, 8'h10);
    send_item(OP_RESP, 32'h0000_0040, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h0000_0311, 32'h0, 8'h00);
  endtask

  task automatic test_restart_and_undefined();
    send_item(OP_SCAN, 32'h0, 32'h0, 8'h00);
    send_item(OpUndefined, 32'h0, 32'h0, 8'h00);
    send_item(OP_RESP, 32'h0000_1234, 32'h0, 8'h00);
    send_item(OP_CAP, 32'h0, 32'h0000_0100, 8'h09);
    send_item(OP_SCAN, 32'h0, 32'h0, 8'h00);
    send_item(OP_RESP, 32'hFFFF_FFFF, 32'h0, 8'h00);
  endtask

  task automatic test_random_configs();
    logic [31:0] mask;
    wait_quiet();
    apply_config(32'h0C03_0000, 32'hFFFF_0000, 8'h00);
    send_gap_max = 14;
    recv_gap_max = 14;
    run_random(320);

    wait_quiet();
    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_gap_max = 0;
    recv_gap_max = 0;
    run_random(280);

    wait_quiet();
    mask = $urandom();
    apply_config(32'($urandom()) & mask, mask, 8'($urandom()));
    send_gap_max = 3;
    recv_gap_max = 14;
    run_random(320);

    wait_quiet();
    apply_config(32'h0000_0000, 32'h0000_0000, 8'($urandom()));
    send_gap_max = 14;
    recv_gap_max = 0;
    run_random(320);

    wait_quiet();
    apply_config($urandom(), $urandom(), 8'h80);
    send_gap_max = 14;
    recv_gap_max = 14;
    run_random(320);
  endtask

  initial begin : result_checker
    int stall;
    pcs_result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, recv_gap_max);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual kind %0d value %h",
                 $time, out_kind_o, out_value_o);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_kind_o !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind,
                   out_kind_o);
          failures++;
        end
        if (out_value_o !== want.value) begin
          $display("%0t: value mismatch, expected %h actual %h", $time, want.value,
                   out_value_o);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_responses();
    test_default_scan();
    test_capability_walk();
    test_restart_and_undefined();
    test_random_configs();
    wait_quiet();
    if (failures == 0) begin
      $display("pci_config_scan_engine verification clean");
    end else begin
      $display("pci_config_scan_engine verification failed");
    end
    $finish;
  end

endmodule
